// ===== rtl/core/scc_min_cost_cover_top_defines.svh =====
// Assertion macros for the SCC minimum-cost cover block.
`ifndef SCC_MIN_COST_COVER_TOP_DEFINES_SVH
`define SCC_MIN_COST_COVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a consequent in the same cycle as its antecedent.
`define SCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scc assertion failed");
// Check a consequent in the cycle after its antecedent.
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc assertion failed");
`else
`define SCC_ASSERT_SAME(label, ante, cons)
`define SCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/scc_pkg.sv =====
// Shared types and constants for the SCC minimum-cost cover block.
`default_nettype none
package scc_pkg;

    localparam logic [1:0] REQ_COST  = 2'd0;
    localparam logic [1:0] REQ_EDGE  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [29:0] WAY_MOD = 30'd1000000007;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  node_index;
        logic [31:0] node_cost;
        logic [9:0]  edge_from;
        logic [9:0]  edge_to;
        logic [10:0] node_count;
    } req_t;

    typedef struct packed {
        logic [41:0] total_min_cost;
        logic [29:0] way_count;
        logic        edges_dropped;
    } res_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_ROOT_RD,
        OP_ROOT_MARK,
        OP_G_INC,
        OP_PUSH,
        OP_TOP_RD,
        OP_TOP_LD,
        OP_FINISH,
        OP_EDGE_RD,
        OP_CUR_INC,
        OP_FVIS_RD,
        OP_FVIS_TAKE,
        OP_S_INIT,
        OP_FIN_RD,
        OP_V_RD,
        OP_G_DEC,
        OP_V_CLAIM,
        OP_C_INIT,
        OP_POP_RD,
        OP_POP_LD,
        OP_BVIS_RD,
        OP_BVIS_TAKE,
        OP_TAKE,
        OP_ACC,
        OP_MOD,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic g_eq_n;
        logic g_zero;
        logic sp_zero;
        logic cur_end;
        logic visit_set;
        logic fwd_match;
        logic bwd_match;
        logic k_zero;
        logic out_free;
        logic clr_last;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_F_ROOT,
        ST_F_ROOT_CHK,
        ST_F_PUSH,
        ST_F_TOP,
        ST_F_TOP_W,
        ST_F_SCAN,
        ST_F_EDGE,
        ST_F_VIS,
        ST_S_INIT,
        ST_S_NEXT,
        ST_S_V,
        ST_S_VCHK,
        ST_S_CINIT,
        ST_C_POP,
        ST_C_POPW,
        ST_C_SCAN,
        ST_C_EDGE,
        ST_C_VIS,
        ST_C_TAKE,
        ST_C_MOD,
        ST_R_OUT
    } ctrl_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/scc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/scc_ctrl.sv =====
// Sequencer for the visit-memory clear after reset, loading, the two search passes and result hand-off.
`default_nettype none
module scc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [1:0]          req_type,
    input  wire scc_pkg::dp_status_t status,
    output logic                     req_ready,
    output scc_pkg::dp_op_t          op
);
    scc_pkg::ctrl_state_t state_reg;
    scc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = scc_pkg::OP_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            scc_pkg::ST_CLR:
            begin
                op = scc_pkg::OP_CLR;
                if (status.clr_last)
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op = scc_pkg::OP_LOAD;
                    if (req_type == scc_pkg::REQ_START)
                    begin
                        state_next = scc_pkg::ST_F_ROOT;
                    end
                end
            end
            scc_pkg::ST_F_ROOT:
            begin
                if (status.g_eq_n)
                begin
                    state_next = scc_pkg::ST_S_INIT;
                end
                else
                begin
                    op         = scc_pkg::OP_ROOT_RD;
                    state_next = scc_pkg::ST_F_ROOT_CHK;
                end
            end
            scc_pkg::ST_F_ROOT_CHK:
            begin
                if (status.visit_set)
                begin
                    op         = scc_pkg::OP_G_INC;
                    state_next = scc_pkg::ST_F_ROOT;
                end
                else
                begin
                    op         = scc_pkg::OP_ROOT_MARK;
                    state_next = scc_pkg::ST_F_PUSH;
                end
            end
            scc_pkg::ST_F_PUSH:
            begin
                op         = scc_pkg::OP_PUSH;
                state_next = scc_pkg::ST_F_TOP;
            end
            scc_pkg::ST_F_TOP:
            begin
                if (status.sp_zero)
                begin
                    op         = scc_pkg::OP_G_INC;
                    state_next = scc_pkg::ST_F_ROOT;
                end
                else
                begin
                    op         = scc_pkg::OP_TOP_RD;
                    state_next = scc_pkg::ST_F_TOP_W;
                end
            end
            scc_pkg::ST_F_TOP_W:
            begin
                op         = scc_pkg::OP_TOP_LD;
                state_next = scc_pkg::ST_F_SCAN;
            end
            scc_pkg::ST_F_SCAN:
            begin
                if (status.cur_end)
                begin
                    op         = scc_pkg::OP_FINISH;
                    state_next = scc_pkg::ST_F_TOP;
                end
                else
                begin
                    op         = scc_pkg::OP_EDGE_RD;
                    state_next = scc_pkg::ST_F_EDGE;
                end
            end
            scc_pkg::ST_F_EDGE:
            begin
                if (status.fwd_match)
                begin
                    op         = scc_pkg::OP_FVIS_RD;
                    state_next = scc_pkg::ST_F_VIS;
                end
                else
                begin
                    op         = scc_pkg::OP_CUR_INC;
                    state_next = scc_pkg::ST_F_SCAN;
                end
            end
            scc_pkg::ST_F_VIS:
            begin
                if (status.visit_set)
                begin
                    op         = scc_pkg::OP_CUR_INC;
                    state_next = scc_pkg::ST_F_SCAN;
                end
                else
                begin
                    op         = scc_pkg::OP_FVIS_TAKE;
                    state_next = scc_pkg::ST_F_PUSH;
                end
            end
            scc_pkg::ST_S_INIT:
            begin
                op         = scc_pkg::OP_S_INIT;
                state_next = scc_pkg::ST_S_NEXT;
            end
            scc_pkg::ST_S_NEXT:
            begin
                if (status.g_zero)
                begin
                    state_next = scc_pkg::ST_R_OUT;
                end
                else
                begin
                    op         = scc_pkg::OP_FIN_RD;
                    state_next = scc_pkg::ST_S_V;
                end
            end
            scc_pkg::ST_S_V:
            begin
                op         = scc_pkg::OP_V_RD;
                state_next = scc_pkg::ST_S_VCHK;
            end
            scc_pkg::ST_S_VCHK:
            begin
                if (status.visit_set)
                begin
                    op         = scc_pkg::OP_V_CLAIM;
                    state_next = scc_pkg::ST_S_CINIT;
                end
                else
                begin
                    op         = scc_pkg::OP_G_DEC;
                    state_next = scc_pkg::ST_S_NEXT;
                end
            end
            scc_pkg::ST_S_CINIT:
            begin
                op         = scc_pkg::OP_C_INIT;
                state_next = scc_pkg::ST_C_POP;
            end
            scc_pkg::ST_C_POP:
            begin
                if (status.sp_zero)
                begin
                    op         = scc_pkg::OP_ACC;
                    state_next = scc_pkg::ST_C_MOD;
                end
                else
                begin
                    op         = scc_pkg::OP_POP_RD;
                    state_next = scc_pkg::ST_C_POPW;
                end
            end
            scc_pkg::ST_C_POPW:
            begin
                op         = scc_pkg::OP_POP_LD;
                state_next = scc_pkg::ST_C_SCAN;
            end
            scc_pkg::ST_C_SCAN:
            begin
                if (status.cur_end)
                begin
                    state_next = scc_pkg::ST_C_POP;
                end
                else
                begin
                    op         = scc_pkg::OP_EDGE_RD;
                    state_next = scc_pkg::ST_C_EDGE;
                end
            end
            scc_pkg::ST_C_EDGE:
            begin
                if (status.bwd_match)
                begin
                    op         = scc_pkg::OP_BVIS_RD;
                    state_next = scc_pkg::ST_C_VIS;
                end
                else
                begin
                    op         = scc_pkg::OP_CUR_INC;
                    state_next = scc_pkg::ST_C_SCAN;
                end
            end
            scc_pkg::ST_C_VIS:
            begin
                if (status.visit_set)
                begin
                    op         = scc_pkg::OP_BVIS_TAKE;
                    state_next = scc_pkg::ST_C_TAKE;
                end
                else
                begin
                    op         = scc_pkg::OP_CUR_INC;
                    state_next = scc_pkg::ST_C_SCAN;
                end
            end
            scc_pkg::ST_C_TAKE:
            begin
                op         = scc_pkg::OP_TAKE;
                state_next = scc_pkg::ST_C_SCAN;
            end
            scc_pkg::ST_C_MOD:
            begin
                op = scc_pkg::OP_MOD;
                if (status.k_zero)
                begin
                    state_next = scc_pkg::ST_S_NEXT;
                end
            end
            scc_pkg::ST_R_OUT:
            begin
                if (status.out_free)
                begin
                    op         = scc_pkg::OP_OUT;
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/scc_datapath.sv =====
// Stores, counters, stacks and accumulators for the SCC search.
`default_nettype none
module scc_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scc_pkg::dp_op_t    op,
    input  wire scc_pkg::req_t      req,
    input  wire logic               res_ready,
    output scc_pkg::res_t           res,
    output logic                    res_valid,
    output scc_pkg::dp_status_t     status
);
    localparam int NW   = $clog2(MAX_NODES);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int CW   = NW + 11;
    localparam int MODW = 30 + NCW;
    localparam int KW   = $clog2(NCW);

    logic [NCW-1:0]  n_reg, n_next, g_reg, g_next, done_reg, done_next, sp_reg, sp_next;
    logic [NW-1:0]   u_reg, u_next, w_reg, w_next;
    logic [ECW-1:0]  cur_reg, cur_next, ecnt_reg, ecnt_next;
    logic            ovf_reg, ovf_next, res_valid_reg, res_valid_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [32:0]     cmin_reg, cmin_next;
    logic [NCW-1:0]  tie_reg, tie_next;
    logic [29:0]     prod_reg, prod_next;
    logic [41:0]     sum_reg, sum_next;
    logic [MODW-1:0] mod_reg, mod_next, mod_thr, mod_sub;
    scc_pkg::res_t   res_reg, res_next;

    logic [NCW-1:0]  g_dec, sp_dec;
    logic [9:0]      e_src, e_dst;
    logic [32:0]     cost_ext;

    logic            cost_we, cost_re;
    logic [NW-1:0]   cost_waddr, cost_raddr;
    logic [31:0]     cost_rdata;
    logic            edge_we, edge_re;
    logic [EAW-1:0]  edge_waddr, edge_raddr;
    logic [19:0]     edge_rdata;
    logic            vis_we, vis_re, vis_wdata, vis_rdata;
    logic [NW-1:0]   vis_waddr, vis_raddr;
    logic            stk_we, stk_re;
    logic [NW-1:0]   stk_waddr, stk_raddr, stk_rdata;
    logic            csr_we, csr_re;
    logic [NW-1:0]   csr_waddr, csr_raddr;
    logic [ECW-1:0]  csr_wdata, csr_rdata;
    logic            fin_we, fin_re;
    logic [NW-1:0]   fin_waddr, fin_raddr, fin_rdata;

    scc_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_cost_ram (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(req.node_cost),
        .re(cost_re), .raddr(cost_raddr), .rdata(cost_rdata)
    );
    scc_ram #(.WIDTH(20), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata({req.edge_from, req.edge_to}),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
    );
    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit_ram (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .re(vis_re), .raddr(vis_raddr), .rdata(vis_rdata)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(w_reg),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );
    scc_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES)) u_cursor_ram (
        .clk(clk), .we(csr_we), .waddr(csr_waddr), .wdata(csr_wdata),
        .re(csr_re), .raddr(csr_raddr), .rdata(csr_rdata)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finish_ram (
        .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(u_reg),
        .re(fin_re), .raddr(fin_raddr), .rdata(fin_rdata)
    );

    assign e_src    = edge_rdata[19:10];
    assign e_dst    = edge_rdata[9:0];
    assign g_dec    = g_reg - 1'b1;
    assign sp_dec   = sp_reg - 1'b1;
    assign cost_ext = {1'b0, cost_rdata};
    assign mod_thr  = MODW'(scc_pkg::WAY_MOD) << k_reg;
    assign mod_sub  = (mod_reg >= mod_thr) ? (mod_reg - mod_thr) : mod_reg;

    always_comb
    begin
        status.g_eq_n    = (g_reg == n_reg);
        status.g_zero    = (g_reg == '0);
        status.sp_zero   = (sp_reg == '0);
        status.cur_end   = (cur_reg == ecnt_reg);
        status.visit_set = vis_rdata;
        status.fwd_match = (CW'(e_src) == CW'(u_reg)) && (CW'(e_dst) < CW'(n_reg));
        status.bwd_match = (CW'(e_dst) == CW'(u_reg)) && (CW'(e_src) < CW'(n_reg));
        status.k_zero    = (k_reg == '0);
        status.out_free  = !res_valid_reg || res_ready;
        status.clr_last  = (g_reg == NCW'(MAX_NODES - 1));
    end

    always_comb
    begin
        n_next         = n_reg;
        g_next         = g_reg;
        done_next      = done_reg;
        sp_next        = sp_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        cur_next       = cur_reg;
        ecnt_next      = ecnt_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        cmin_next      = cmin_reg;
        tie_next       = tie_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        mod_next       = mod_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        cost_we    = 1'b0;
        cost_waddr = NW'(req.node_index);
        cost_re    = 1'b0;
        cost_raddr = w_reg;
        edge_we    = 1'b0;
        edge_waddr = ecnt_reg[EAW-1:0];
        edge_re    = 1'b0;
        edge_raddr = cur_reg[EAW-1:0];
        vis_we     = 1'b0;
        vis_waddr  = g_reg[NW-1:0];
        vis_wdata  = 1'b0;
        vis_re     = 1'b0;
        vis_raddr  = g_reg[NW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[NW-1:0];
        stk_re     = 1'b0;
        stk_raddr  = sp_dec[NW-1:0];
        csr_we     = 1'b0;
        csr_waddr  = sp_reg[NW-1:0];
        csr_wdata  = '0;
        csr_re     = 1'b0;
        csr_raddr  = sp_dec[NW-1:0];
        fin_we     = 1'b0;
        fin_waddr  = done_reg[NW-1:0];
        fin_re     = 1'b0;
        fin_raddr  = g_dec[NW-1:0];

        case (op)
            scc_pkg::OP_CLR:
            begin
                vis_we = 1'b1;
                g_next = g_reg + 1'b1;
            end
            scc_pkg::OP_LOAD:
            begin
                case (req.req_type)
                    scc_pkg::REQ_COST:
                    begin
                        cost_we = (32'(req.node_index) < 32'(MAX_NODES));
                    end
                    scc_pkg::REQ_EDGE:
                    begin
                        if (32'(ecnt_reg) < 32'(MAX_EDGES))
                        begin
                            edge_we   = 1'b1;
                            ecnt_next = ecnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    scc_pkg::REQ_START:
                    begin
                        n_next    = (32'(req.node_count) > 32'(MAX_NODES)) ?
                                    NCW'(MAX_NODES) : NCW'(req.node_count);
                        g_next    = '0;
                        done_next = '0;
                        sp_next   = '0;
                        prod_next = 30'd1;
                        sum_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            scc_pkg::OP_ROOT_RD:
            begin
                vis_re = 1'b1;
            end
            scc_pkg::OP_ROOT_MARK:
            begin
                vis_we    = 1'b1;
                vis_wdata = 1'b1;
                w_next    = g_reg[NW-1:0];
            end
            scc_pkg::OP_G_INC:
            begin
                g_next = g_reg + 1'b1;
            end
            scc_pkg::OP_PUSH:
            begin
                stk_we  = 1'b1;
                csr_we  = 1'b1;
                sp_next = sp_reg + 1'b1;
            end
            scc_pkg::OP_TOP_RD:
            begin
                stk_re = 1'b1;
                csr_re = 1'b1;
            end
            scc_pkg::OP_TOP_LD:
            begin
                u_next   = stk_rdata;
                cur_next = csr_rdata;
            end
            scc_pkg::OP_FINISH:
            begin
                fin_we    = 1'b1;
                done_next = done_reg + 1'b1;
                sp_next   = sp_dec;
            end
            scc_pkg::OP_EDGE_RD:
            begin
                edge_re = 1'b1;
            end
            scc_pkg::OP_CUR_INC:
            begin
                cur_next = cur_reg + 1'b1;
            end
            scc_pkg::OP_FVIS_RD:
            begin
                vis_re    = 1'b1;
                vis_raddr = NW'(e_dst);
            end
            scc_pkg::OP_FVIS_TAKE:
            begin
                // resume this frame past the edge just followed
                csr_we    = 1'b1;
                csr_waddr = sp_dec[NW-1:0];
                csr_wdata = cur_reg + 1'b1;
                vis_we    = 1'b1;
                vis_waddr = NW'(e_dst);
                vis_wdata = 1'b1;
                w_next    = NW'(e_dst);
            end
            scc_pkg::OP_S_INIT:
            begin
                g_next = done_reg;
            end
            scc_pkg::OP_FIN_RD:
            begin
                fin_re = 1'b1;
            end
            scc_pkg::OP_V_RD:
            begin
                w_next    = fin_rdata;
                vis_re    = 1'b1;
                vis_raddr = fin_rdata;
            end
            scc_pkg::OP_G_DEC:
            begin
                g_next = g_dec;
            end
            scc_pkg::OP_V_CLAIM:
            begin
                vis_we    = 1'b1;
                vis_waddr = w_reg;
                cost_re   = 1'b1;
            end
            scc_pkg::OP_C_INIT:
            begin
                cmin_next = cost_ext;
                tie_next  = NCW'(1);
                stk_we    = 1'b1;
                sp_next   = sp_reg + 1'b1;
            end
            scc_pkg::OP_POP_RD:
            begin
                stk_re  = 1'b1;
                sp_next = sp_dec;
            end
            scc_pkg::OP_POP_LD:
            begin
                u_next   = stk_rdata;
                cur_next = '0;
            end
            scc_pkg::OP_BVIS_RD:
            begin
                vis_re    = 1'b1;
                vis_raddr = NW'(e_src);
            end
            scc_pkg::OP_BVIS_TAKE:
            begin
                vis_we     = 1'b1;
                vis_waddr  = NW'(e_src);
                cost_re    = 1'b1;
                cost_raddr = NW'(e_src);
                w_next     = NW'(e_src);
            end
            scc_pkg::OP_TAKE:
            begin
                if (cost_ext < cmin_reg)
                begin
                    cmin_next = cost_ext;
                    tie_next  = NCW'(1);
                end
                else if (cost_ext == cmin_reg)
                begin
                    tie_next = tie_reg + 1'b1;
                end
                stk_we   = 1'b1;
                sp_next  = sp_reg + 1'b1;
                cur_next = cur_reg + 1'b1;
            end
            scc_pkg::OP_ACC:
            begin
                sum_next = sum_reg + 42'(cmin_reg);
                mod_next = MODW'(prod_reg) * MODW'(tie_reg);
                k_next   = KW'(NCW - 1);
            end
            scc_pkg::OP_MOD:
            begin
                // restoring reduction, one shifted modulus per step
                mod_next = mod_sub;
                k_next   = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    prod_next = mod_sub[29:0];
                    g_next    = g_dec;
                end
            end
            scc_pkg::OP_OUT:
            begin
                res_next.total_min_cost = sum_reg;
                res_next.way_count      = prod_reg;
                res_next.edges_dropped  = ovf_reg;
                res_valid_next          = 1'b1;
                ecnt_next               = '0;
                ovf_next                = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            g_reg         <= '0;
            done_reg      <= '0;
            sp_reg        <= '0;
            u_reg         <= '0;
            w_reg         <= '0;
            cur_reg       <= '0;
            ecnt_reg      <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            g_reg         <= g_next;
            done_reg      <= done_next;
            sp_reg        <= sp_next;
            u_reg         <= u_next;
            w_reg         <= w_next;
            cur_reg       <= cur_next;
            ecnt_reg      <= ecnt_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmin_reg <= cmin_next;
        tie_reg  <= tie_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        mod_reg  <= mod_next;
        res_reg  <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/core/scc_min_cost_cover_top.sv =====
// SCC minimum-cost cover: loads a graph, then runs a two-pass SCC search.
//
// Request channel (req_valid/req_ready, payload req): each beat sets one node
// cost, appends one directed edge, or starts the search over node_count nodes.
// Cost and edge beats are taken while idle and give no result. A start beat
// gives exactly one result beat on res_valid/res_ready: the sum of component
// minimum costs, the product of their tie counts mod 1000000007, and a flag
// for edges dropped at a full edge store. After a start the edge store is
// empty again; costs are kept.
// The run time of a start is set by the edge scan of every stack frame,
// which reads the edge memory entry by entry, from the first stored edge to
// the last, in both passes.
// After reset the visit memory is cleared, one entry a cycle, over all
// MAX_NODES entries; req_ready stays low during that sweep.
// A result waits in an output register while res_ready is low; cost and edge
// beats are still taken, but the next result waits until the register frees.
`default_nettype none
`include "scc_min_cost_cover_top_defines.svh"
module scc_min_cost_cover_top #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire scc_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output scc_pkg::res_t      res
);
    scc_pkg::dp_op_t     op;
    scc_pkg::dp_status_t status;

    scc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_type(req.req_type),
        .status(status),
        .req_ready(req_ready),
        .op(op)
    );

    scc_datapath #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .op(op),
        .req(req),
        .res_ready(res_ready),
        .res(res),
        .res_valid(res_valid),
        .status(status)
    );

    `SCC_ASSERT_NEXT(a_start_busy, req_valid && req_ready && req.req_type == scc_pkg::REQ_START, !req_ready)
    `SCC_ASSERT_SAME(a_way_reduced, $rose(res_valid), res.way_count < scc_pkg::WAY_MOD)
    `SCC_ASSERT_SAME(a_result_idle, $rose(res_valid), req_ready)
endmodule
`default_nettype wire
